FILE: design/stdd_pkg.sv
package stdd_pkg;

    localparam int ROW_BYTES     = 52;
    localparam int SCREEN_PIXELS = 400;
    localparam int LIGHT_MAPS    = 32;
    localparam int GRAY_LEVELS   = 65;
    localparam int TEX_SIZE      = 4096;
    localparam int MAX_OUT       = 51;
    localparam int GRAY_SIZE     = LIGHT_MAPS * 256;
    localparam int DITHER_SIZE   = GRAY_LEVELS * 4;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_TEX    = 2'd1,
        OP_GRAY   = 2'd2,
        OP_DITHER = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_LOW_DETAIL = 2'd0,
        CFG_WINDOW_X   = 2'd1,
        CFG_WINDOW_Y   = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_ISSUE,
        BS_DRAIN,
        BS_FLUSH
    } t_bstate;

    typedef struct packed {
        logic [1:0]         operation;
        logic [12:0]        table_index;
        logic [7:0]         table_data;
        logic [8:0]         x_start;
        logic [8:0]         x_end;
        logic [7:0]         span_row;
        logic [4:0]         light_map;
        logic signed [31:0] u_pos;
        logic signed [31:0] v_pos;
        logic signed [31:0] u_step;
        logic signed [31:0] v_step;
    } t_in_word;

    typedef struct packed {
        logic [13:0] byte_addr;
        logic [7:0]  write_data;
        logic [7:0]  bit_mask;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic       low_detail;
        logic [8:0] window_x;
        logic [7:0] window_y;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [12:0] index;
        logic [7:0]  data;
        logic [10:0] col0;
        logic [8:0]  count;
        logic [1:0]  drow;
        logic [4:0]  light;
        logic [13:0] base;
        logic [31:0] pos;
        logic [31:0] step;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_out;

endpackage

FILE: design/span_texture_dither_drawer.sv
// channel | valid      | stall       | word
// in      | i_in_valid | o_in_stall  | i_in_word  (t_in_word)
// out     | o_out_valid| i_out_stall | o_out_word (t_out_word)
// cfg     | i_cfg_we   | -           | i_cfg_index / i_cfg_data
// The back end writes loads into its tables straight from the queue while idle.
// A span issues its pixels (two columns each in low-detail mode), then drains
// the three-stage texel/gray/dither memory pipeline and flushes the last byte.
// A two-word command queue decouples input from drawing.
// Output stall freezes the whole back-end pipeline while an output word is valid.
// Synchronous active-low reset clears control and config; tables are unset.
module span_texture_dither_drawer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stdd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stdd_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);
    import stdd_pkg::*;

    t_cfg       r_cfg;
    t_queue_out w_queue;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LOW_DETAIL: r_cfg.low_detail <= i_cfg_data[0];
                CFG_WINDOW_X:   r_cfg.window_x   <= i_cfg_data;
                CFG_WINDOW_Y:   r_cfg.window_y   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    stdd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .i_pop      (w_pop),
        .o_queue    (w_queue)
    );

    stdd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_low_detail (r_cfg.low_detail),
        .i_queue      (w_queue),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );

endmodule

FILE: design/stdd_front.sv
module stdd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stdd_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stdd_pkg::t_in_word  i_in_word,
    input  logic                i_pop,
    output stdd_pkg::t_queue_out o_queue
);
    import stdd_pkg::*;

    t_cmd        r_q [QUEUE_DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt, n_cnt;
    t_cmd        w_cmd;
    logic        w_keep, w_push, w_pop;
    logic [8:0]  w_row;
    logic [22:0] w_base;

    always_comb begin
        w_row  = {1'b0, i_in_word.span_row} + {1'b0, i_cfg.window_y};
        w_base = 23'(w_row) * 23'(ROW_BYTES);
        w_cmd.op    = t_op'(i_in_word.operation);
        w_cmd.index = i_in_word.table_index;
        w_cmd.data  = i_in_word.table_data;
        w_cmd.col0  = i_cfg.low_detail ?
                      11'({1'b0, i_cfg.window_x}) + 11'({i_in_word.x_start, 1'b0}) :
                      11'({1'b0, i_cfg.window_x}) + 11'(i_in_word.x_start);
        w_cmd.count = i_in_word.x_end - i_in_word.x_start;
        w_cmd.drow  = i_in_word.span_row[1:0];
        w_cmd.light = i_in_word.light_map;
        w_cmd.base  = w_base[13:0];
        w_cmd.pos   = {i_in_word.u_pos[21:6], i_in_word.v_pos[21:6]};
        w_cmd.step  = {i_in_word.u_step[21:6], i_in_word.v_step[21:6]};
        unique case (t_op'(i_in_word.operation))
            OP_DRAW:   w_keep = i_in_word.x_end >= i_in_word.x_start;
            OP_TEX:    w_keep = 32'(i_in_word.table_index) < TEX_SIZE;
            OP_GRAY:   w_keep = 32'(i_in_word.table_index) < GRAY_SIZE;
            OP_DITHER: w_keep = 32'(i_in_word.table_index) < DITHER_SIZE;
            default:   w_keep = 1'b0;
        endcase
    end

    assign o_in_stall = r_cnt == 2'(QUEUE_DEPTH);
    assign w_push     = i_in_valid && !o_in_stall && w_keep;
    assign w_pop      = i_pop && r_cnt != 2'd0;
    assign o_queue.valid = r_cnt != 2'd0;
    assign o_queue.cmd   = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

endmodule

FILE: design/stdd_back.sv
module stdd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_low_detail,
    input  stdd_pkg::t_queue_out i_queue,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output stdd_pkg::t_out_word  o_out_word
);
    import stdd_pkg::*;

    logic [7:0] r_tex    [TEX_SIZE];
    logic [6:0] r_gray   [GRAY_SIZE];
    logic [7:0] r_dither [DITHER_SIZE];

    t_bstate     r_state, n_state;
    logic [31:0] r_pos, r_step;
    logic [10:0] r_col;
    logic [8:0]  r_left;
    logic        r_phase, r_ld;
    logic [4:0]  r_light;
    logic [1:0]  r_drow;
    logic [13:0] r_base;

    logic        r_v1, r_v2, r_v3;
    logic [10:0] r_col1, r_col2, r_col3;
    logic [7:0]  r_tq, r_dq;
    logic [6:0]  r_gq;

    logic        r_have;
    logic [7:0]  r_cur, r_data, r_mask;
    logic [5:0]  r_cnt;
    logic        r_ov;
    t_out_word   r_ow;

    logic        w_adv, w_issue, w_take, w_plot, w_flush;
    logic [11:0] w_spot;
    logic [6:0]  w_gsat;
    logic [8:0]  w_daddr;
    logic [7:0]  w_bit, w_byte;
    logic        w_change;

    assign w_adv   = !r_ov || !i_out_stall;
    assign w_spot  = {r_pos[15:10], r_pos[31:26]};
    assign w_gsat  = (32'(r_gq) >= GRAY_LEVELS) ? 7'(GRAY_LEVELS - 1) : r_gq;
    assign w_daddr = 9'({w_gsat, 2'b00}) + 9'(r_drow);
    assign w_bit   = 8'h80 >> r_col3[2:0];
    assign w_byte  = r_col3[10:3];
    assign w_plot  = w_adv && r_v3 && 32'(r_col3) < SCREEN_PIXELS;
    assign w_change = r_have && w_byte != r_cur;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        w_take  = 1'b0;
        w_issue = 1'b0;
        w_flush = 1'b0;
        unique case (r_state)
            BS_IDLE: begin
                if (i_queue.valid) begin
                    o_pop = 1'b1;
                    if (i_queue.cmd.op == OP_DRAW) begin
                        w_take  = 1'b1;
                        n_state = BS_ISSUE;
                    end
                end
            end
            BS_ISSUE: begin
                if (w_adv) begin
                    w_issue = 1'b1;
                    if (r_left == 9'd0 && (!r_ld || r_phase)) begin
                        n_state = BS_DRAIN;
                    end
                end
            end
            BS_DRAIN: begin
                if (!r_v1 && !r_v2 && !r_v3) begin
                    n_state = BS_FLUSH;
                end
            end
            BS_FLUSH: begin
                if (!r_have || 32'(r_cnt) >= MAX_OUT) begin
                    n_state = BS_IDLE;
                end else if (w_adv) begin
                    w_flush = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_queue.cmd.op == OP_TEX) begin
            r_tex[i_queue.cmd.index[11:0]] <= i_queue.cmd.data;
        end
        if (w_issue) begin
            r_tq <= r_tex[w_spot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_queue.cmd.op == OP_GRAY) begin
            r_gray[i_queue.cmd.index] <= i_queue.cmd.data[6:0];
        end
        if (w_adv) begin
            r_gq <= r_gray[{r_light, r_tq}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_queue.cmd.op == OP_DITHER) begin
            r_dither[i_queue.cmd.index[8:0]] <= i_queue.cmd.data;
        end
        if (w_adv) begin
            r_dq <= r_dither[w_daddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pos   <= i_queue.cmd.pos;
            r_step  <= i_queue.cmd.step;
            r_col   <= i_queue.cmd.col0;
            r_left  <= i_queue.cmd.count;
            r_light <= i_queue.cmd.light;
            r_drow  <= i_queue.cmd.drow;
            r_base  <= i_queue.cmd.base;
            r_ld    <= i_low_detail;
            r_phase <= 1'b0;
        end else if (w_issue) begin
            r_col <= r_col + 11'd1;
            if (!r_ld || r_phase) begin
                r_pos   <= r_pos + r_step;
                r_phase <= 1'b0;
                r_left  <= r_left - 9'd1;
            end else begin
                r_phase <= 1'b1;
            end
        end
        if (w_adv) begin
            r_col1 <= r_col;
            r_col2 <= r_col1;
            r_col3 <= r_col2;
        end
        if (w_plot) begin
            if (!r_have || w_change) begin
                r_cur  <= w_byte;
                r_data <= r_dq & w_bit;
                r_mask <= w_bit;
            end else begin
                r_data <= r_data | (r_dq & w_bit);
                r_mask <= r_mask | w_bit;
            end
        end
        if (w_adv) begin
            r_ow.byte_addr  <= r_base + 14'(r_cur);
            r_ow.write_data <= r_data;
            r_ow.bit_mask   <= r_mask;
            r_ow.last       <= w_flush || 32'(r_cnt) == MAX_OUT - 1;
        end
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_have  <= 1'b0;
            r_cnt   <= 6'd0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_v1 <= w_issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_ov <= 1'b0;
            end
            if (w_take) begin
                r_have <= 1'b0;
                r_cnt  <= 6'd0;
            end else if (w_flush) begin
                r_have <= 1'b0;
                r_ov   <= 1'b1;
                r_cnt  <= r_cnt + 6'd1;
            end else if (w_plot) begin
                r_have <= 1'b1;
                if (w_change && 32'(r_cnt) < MAX_OUT) begin
                    r_ov  <= 1'b1;
                    r_cnt <= r_cnt + 6'd1;
                end
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_ow;

endmodule

FILE: design/stdd_checker.sv
module stdd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input stdd_pkg::t_out_word o_out_word
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid) else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.bit_mask != 8'd0) else $error("empty mask");

    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.write_data & ~o_out_word.bit_mask) == 8'd0)
        else $error("data outside mask");

endmodule

bind span_texture_dither_drawer stdd_checker u_stdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

FILE: tb/span_texture_dither_drawer_test.sv
`timescale 1ns / 100ps

module span_texture_dither_drawer_test;
    import stdd_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;

    span_texture_dither_drawer uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // shadow tables and config
    logic [7:0] tex_mem [TEX_SIZE];
    logic [6:0] gray_mem [GRAY_SIZE];
    logic [7:0] dith_mem [DITHER_SIZE];
    logic       m_low;
    logic [8:0] m_wx;
    logic [7:0] m_wy;

    // draws stay inside the loaded parts of the tables: texture rows v = 0..1,
    // texel values 0..7, light maps 0, 7 and 31, gray levels 0..7 and 56..64
    int         light_set [3] = '{0, 7, 31};

    t_in_word  pending_words [$];
    t_out_word expected_writes [$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    bit        driver_hold = 1'b0;

    // byte merge state of the span predictor
    int        acc_n;
    bit        acc_have;
    int        acc_cur;
    int        acc_base;
    logic [7:0] acc_data, acc_mask;

    task automatic push_byte(bit lst);
        t_out_word w;
        if (acc_n >= MAX_OUT) return;
        w.byte_addr = 14'(acc_base + acc_cur);
        w.write_data = acc_data;
        w.bit_mask = acc_mask;
        w.last = lst;
        expected_writes.push_back(w);
        acc_n++;
    endtask

    task automatic put_pixel(int col, logic [7:0] shade);
        logic [7:0] b;
        if (col >= SCREEN_PIXELS) return;
        if (acc_have && (col >> 3) != acc_cur) begin
            push_byte(1'b0);
            acc_have = 0;
        end
        if (!acc_have) begin
            acc_have = 1;
            acc_cur = col >> 3;
            acc_data = '0;
            acc_mask = '0;
        end
        b = 8'h80 >> (col & 7);
        acc_mask |= b;
        acc_data |= shade & b;
    endtask

    task automatic predict_word(t_in_word w);
        int lm, g, cnt, spot;
        logic [31:0] pos, step;
        logic [7:0] shade;
        case (t_op'(w.operation))
            OP_TEX: if (w.table_index < TEX_SIZE) tex_mem[w.table_index] = w.table_data;
            OP_GRAY: if (w.table_index < GRAY_SIZE) gray_mem[w.table_index] = w.table_data[6:0];
            OP_DITHER: if (w.table_index < DITHER_SIZE) dith_mem[w.table_index] = w.table_data;
            default: begin
                if (w.x_end < w.x_start) return;
                lm = (w.light_map >= LIGHT_MAPS) ? LIGHT_MAPS - 1 : w.light_map;
                pos = {w.u_pos[21:6], w.v_pos[21:6]};
                step = {w.u_step[21:6], w.v_step[21:6]};
                acc_n = 0; acc_have = 0; acc_cur = 0;
                acc_base = (int'(w.span_row) + int'(m_wy)) * ROW_BYTES;
                cnt = w.x_end - w.x_start;
                for (int i = 0; i <= cnt; i++) begin
                    spot = {pos[15:10], pos[31:26]};
                    g = gray_mem[lm * 256 + tex_mem[spot]];
                    if (g >= GRAY_LEVELS) g = GRAY_LEVELS - 1;
                    shade = dith_mem[g * 4 + w.span_row[1:0]];
                    if (m_low) begin
                        put_pixel(m_wx + 2 * (w.x_start + i), shade);
                        put_pixel(m_wx + 2 * (w.x_start + i) + 1, shade);
                    end else begin
                        put_pixel(m_wx + w.x_start + i, shade);
                    end
                    pos += step;
                end
                if (acc_have) begin
                    if (acc_n < MAX_OUT) push_byte(1'b1);
                    else expected_writes[$].last = 1'b1;
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // accept flags latched at the rising edge
    logic in_stall_q = 1'b0;
    always @(posedge clk) begin
        in_stall_q <= in_valid && !(rst_n && !in_stall);
        if (rst_n && in_valid && !in_stall) begin
            predict_word(in_word);
        end
    end

    // driver
    int send_gap = 0;
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall_q) begin
                if (pending_words.size() > 0 && send_gap == 0 && !driver_hold) begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (!in_valid) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                else if (pending_words.size() > 0 && !driver_hold) begin
                    in_word <= pending_words.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end
            end
        end
    end

    // receiver stall
    int stall_left = 0;
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) < 3) begin
            stall_left <= pick_gap();
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        t_out_word w;
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (out_valid && !out_stall) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch("unexpected write", out_word, 0);
                end else begin
                    w = expected_writes.pop_front();
                    if (out_word.byte_addr !== w.byte_addr)
                        report_mismatch("byte_addr", out_word.byte_addr, w.byte_addr);
                    if ((out_word.write_data & w.bit_mask) !== w.write_data)
                        report_mismatch("write_data", out_word.write_data, w.write_data);
                    if (out_word.bit_mask !== w.bit_mask)
                        report_mismatch("bit_mask", out_word.bit_mask, w.bit_mask);
                    if (out_word.last !== w.last)
                        report_mismatch("last", out_word.last, w.last);
                end
            end
            if (idle_cycles > 20000) begin
                $display("span_texture_dither_drawer verification failed");
                $finish;
            end
        end
    end

    function automatic t_in_word load_word(t_op op, int idx, int dat);
        t_in_word w;
        w = '0;
        w.operation = op;
        w.table_index = 13'(idx);
        w.table_data = 8'(dat);
        return w;
    endfunction

    function automatic int gray_level();
        if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
        return $urandom_range(56, 127);
    endfunction

    function automatic int gray_byte();
        return int'($urandom_range(0, 1)) * 128 + gray_level();
    endfunction

    function automatic int dither_level();
        if ($urandom_range(0, 1) == 0) return $urandom_range(0, 7);
        return $urandom_range(56, GRAY_LEVELS - 1);
    endfunction

    function automatic t_in_word rand_tex_load();
        if ($urandom_range(0, 1) == 0)
            return load_word(OP_TEX, $urandom_range(0, 127), $urandom_range(0, 7));
        return load_word(OP_TEX, $urandom_range(TEX_SIZE, 8191), $urandom);
    endfunction

    function automatic t_in_word rand_gray_load();
        return load_word(OP_GRAY, light_set[$urandom_range(0, 2)] * 256 +
                         $urandom_range(0, 7), gray_byte());
    endfunction

    function automatic t_in_word rand_dither_load();
        if ($urandom_range(0, 3) == 0)
            return load_word(OP_DITHER, $urandom_range(DITHER_SIZE, 300), $urandom);
        return load_word(OP_DITHER, dither_level() * 4 + $urandom_range(0, 3), $urandom);
    endfunction

    function automatic t_in_word span_word(int xs, int xe, int row, int lm,
                                           logic [31:0] u, logic [31:0] v,
                                           logic [31:0] du, logic [31:0] dv);
        t_in_word w;
        w.operation = OP_DRAW;
        w.table_index = 13'($urandom);
        w.table_data = 8'($urandom);
        w.x_start = 9'(xs);
        w.x_end = 9'(xe);
        w.span_row = 8'(row);
        w.light_map = 5'(lm);
        w.u_pos = u; w.v_pos = v; w.u_step = du; w.v_step = dv;
        return w;
    endfunction

    // v walks at most 800/1024 of a texel, up from row 0 or down from row 1
    function automatic t_in_word random_span(int maxlen);
        int xs, len, s;
        bit down;
        logic [31:0] v, dv;
        xs = $urandom_range(0, 399);
        len = $urandom_range(0, maxlen);
        if (xs + len > 399) len = 399 - xs;
        down = 1'($urandom_range(0, 1));
        s = $urandom_range(0, 2);
        v = $urandom;
        v[21:16] = down ? 6'd1 : 6'd0;
        dv = $urandom;
        dv[21:6] = 16'(down ? -s : s);
        return span_word(xs, xs + len, $urandom_range(0, 239), light_set[$urandom_range(0, 2)],
                         $urandom, v, $urandom, dv);
    endfunction

    task automatic write_cfg(t_cfg_index idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LOW_DETAIL: m_low = val[0];
            CFG_WINDOW_X: m_wx = 9'(val);
            CFG_WINDOW_Y: m_wy = 8'(val);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_writes.size() > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    initial begin
        m_low = 0; m_wx = 0; m_wy = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // load every entry that a draw can reach
        for (int i = 0; i < 128; i++)
            pending_words.push_back(load_word(OP_TEX, i, $urandom_range(0, 7)));
        for (int m = 0; m < 3; m++)
            for (int c = 0; c < 8; c++)
                pending_words.push_back(load_word(OP_GRAY, light_set[m] * 256 + c,
                                                  gray_byte()));
        for (int lvl = 0; lvl < GRAY_LEVELS; lvl++)
            if (lvl < 8 || lvl >= 56)
                for (int r = 0; r < 4; r++)
                    pending_words.push_back(load_word(OP_DITHER, lvl * 4 + r, $urandom));
        // out-of-range texture and dither loads are ignored; the gray loads are in range
        pending_words.push_back(load_word(OP_TEX, 8191, 8'hff));
        pending_words.push_back(load_word(OP_GRAY, 8191, 8'h80));
        pending_words.push_back(load_word(OP_DITHER, DITHER_SIZE, 8'h55));
        pending_words.push_back(load_word(OP_DITHER, 8191, 8'haa));
        pending_words.push_back(load_word(OP_GRAY, 5, 8'hff));
        pending_words.push_back(load_word(OP_GRAY, 31 * 256 + 7, 8'h7f));

        // directed spans
        pending_words.push_back(span_word(0, 0, 0, 0, 0, 0, 0, 0));
        pending_words.push_back(span_word(399, 399, 239, 31, 32'hffffffff,
                                          32'hffc1ffff, 32'hffffffff, 32'hffffffff));
        pending_words.push_back(span_word(10, 5, 3, 1, 0, 0, 0, 0));
        pending_words.push_back(span_word(0, 399, 1, 7, 32'h80000000, 32'h7fc1ffff,
                                          32'h00010000, 32'hffffff80));
        pending_words.push_back(span_word(3, 12, 2, 31, 32'h12345678, 32'h9a80def0,
                                          32'h7fffffff, 32'h80000000));
        pending_words.push_back(span_word(7, 9, 0, 0, 0, 0, 32'h00400000, 32'h00008000));
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin write_cfg(CFG_LOW_DETAIL, 1); write_cfg(CFG_WINDOW_X, 0);
                         write_cfg(CFG_WINDOW_Y, 0); end
                1: begin write_cfg(CFG_WINDOW_X, 399); write_cfg(CFG_WINDOW_Y, 239); end
                2: begin write_cfg(CFG_LOW_DETAIL, 0); end
                3: begin write_cfg(CFG_WINDOW_X, 1); write_cfg(CFG_WINDOW_Y, 100); end
                4: begin write_cfg(CFG_LOW_DETAIL, 1); write_cfg(CFG_WINDOW_X, 7); end
                default: begin write_cfg(CFG_LOW_DETAIL, 0);
                         write_cfg(CFG_WINDOW_X, $urandom_range(0, 399));
                         write_cfg(CFG_WINDOW_Y, $urandom_range(0, 239)); end
            endcase
            if (phase == 0) begin
                pending_words.push_back(span_word(0, 399, 0, 0, 0, 0, 32'h10000, 0));
                pending_words.push_back(span_word(3, 4, 1, 7, 0, 0, 0, 0));
                pending_words.push_back(span_word(199, 210, 2, 0, 0, 0, 0, 32'h100));
            end
            for (int k = 0; k < 45; k++) begin
                case ($urandom_range(0, 9))
                    0: pending_words.push_back(rand_tex_load());
                    1: pending_words.push_back(rand_dither_load());
                    2: pending_words.push_back(rand_gray_load());
                    3: pending_words.push_back(random_span(399));
                    default: pending_words.push_back(random_span(20));
                endcase
                if (k == 40) begin
                    while (pending_words.size() > 0 || in_valid) @(posedge clk);
                    driver_hold = 1'b1;
                    while (expected_writes.size() > 0) @(posedge clk);
                    driver_hold = 1'b0;
                end
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("span_texture_dither_drawer verification clean");
        end else begin
            $display("span_texture_dither_drawer verification failed");
        end
        $finish;
    end
endmodule
